@@ rtl/tder_pkg.sv @@
`default_nettype none

package tder_pkg;

    localparam int NUM_W = 32;
    localparam int HDR_W = 32;

    localparam logic [2:0] TYPE_DTAG  = 3'd2;
    localparam logic [2:0] TYPE_UDATA = 3'd6;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;
    localparam logic [7:0] BYTE_CLOSE = 8'h00;

    localparam logic CFG_EXPECTED_TAG  = 1'b0;
    localparam logic CFG_OPTIONAL_MODE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_PAST_END   = 3'd1,
        ST_ZERO_OCTET = 3'd2,
        ST_NOT_DTAG   = 3'd3,
        ST_WRONG_TAG  = 3'd4,
        ST_NOT_UDATA  = 3'd5,
        ST_BAD_DIGIT  = 3'd6,
        ST_NO_CLOSE   = 3'd7
    } t_status;

    typedef struct packed {
        t_status           status;
        logic              present;
        logic [NUM_W-1:0]  number;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/tder_ofifo.sv @@
`default_nettype none

module tder_ofifo
    import tder_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_can_push,
    output logic         o_valid,
    input  wire logic    i_pop_ready,
    output t_result      o_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_can_push = (r_count != 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign o_data     = r_mem[r_rd_ptr];
    assign pop        = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/tagged_decimal_element_reader.sv @@
`default_nettype none

// Reads one binary-XML element (DTag header, UDATA header, decimal digits,
// close byte) from a stream of one byte per item and gives one result per
// element: success with the parsed number, absence, or an error code; after
// any result the reader waits for a new tag header. Each byte is handled in
// the cycle it is accepted, so one byte per clock is sustained; results go
// into a two-entry output queue, and the input stalls only while both queue
// entries are held by results not yet taken.
module tagged_decimal_element_reader
    import tder_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_input,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic             o_present,
    output logic [31:0]      o_number
);

    typedef enum logic [1:0] {
        PH_TAG    = 2'd0,
        PH_DATA   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_CLOSE  = 2'd3
    } t_phase;

    logic [31:0]       r_expected_tag;
    logic              r_optional_mode;
    t_phase            r_phase,      n_phase;
    logic [HDR_W-1:0]  r_acc,        n_acc;
    logic              r_first_seen, n_first_seen;
    logic [HDR_W-1:0]  r_digits,     n_digits;
    logic [NUM_W-1:0]  r_num,        n_num;
    logic              r_bad,        n_bad;

    logic              in_fire;
    logic              emit;
    t_result           res;
    t_result           q_data;
    logic [HDR_W-1:0]  hdr_val;
    logic [2:0]        hdr_kind;
    logic              is_digit;
    logic [NUM_W-1:0]  num_x10;

    assign in_fire  = i_in_valid && o_in_ready;
    assign hdr_val  = {r_acc[HDR_W-5:0], i_data_byte[6:3]};
    assign hdr_kind = i_data_byte[2:0];
    assign is_digit = (i_data_byte >= CHR_ZERO) && (i_data_byte <= CHR_NINE);
    assign num_x10  = (r_num << 3) + (r_num << 1);

    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_first_seen = r_first_seen;
        n_digits     = r_digits;
        n_num        = r_num;
        n_bad        = r_bad;
        emit         = 1'b0;
        res.status   = ST_OK;
        res.present  = 1'b0;
        res.number   = '0;

        case (r_phase)
            PH_TAG, PH_DATA: begin
                if (!r_first_seen && i_data_byte == BYTE_CLOSE) begin
                    emit = 1'b1;
                    res.status = (r_phase == PH_TAG && r_optional_mode) ? ST_OK
                                                                        : ST_ZERO_OCTET;
                end else if (!i_data_byte[7]) begin
                    n_first_seen = 1'b1;
                    n_acc = {r_acc[HDR_W-8:0], i_data_byte[6:0]};
                    if (i_end_of_input) begin
                        emit = 1'b1;
                        res.status = ST_PAST_END;
                    end
                end else begin
                    // final header octet
                    n_acc        = '0;
                    n_first_seen = 1'b0;
                    if (r_phase == PH_TAG) begin
                        if (hdr_kind != TYPE_DTAG) begin
                            emit = 1'b1;
                            res.status = r_optional_mode ? ST_OK : ST_NOT_DTAG;
                        end else if (hdr_val != r_expected_tag) begin
                            emit = 1'b1;
                            res.status = r_optional_mode ? ST_OK : ST_WRONG_TAG;
                        end else begin
                            n_phase = PH_DATA;
                            if (i_end_of_input) begin
                                emit = 1'b1;
                                res.status = ST_PAST_END;
                            end
                        end
                    end else begin
                        if (hdr_kind != TYPE_UDATA) begin
                            emit = 1'b1;
                            res.status = ST_NOT_UDATA;
                        end else begin
                            n_digits = hdr_val;
                            n_num    = '0;
                            n_bad    = 1'b0;
                            n_phase  = (hdr_val != '0) ? PH_DIGITS : PH_CLOSE;
                            if (i_end_of_input) begin
                                emit = 1'b1;
                                res.status = ST_PAST_END;
                            end
                        end
                    end
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    n_num = num_x10 + NUM_W'(i_data_byte - CHR_ZERO);
                end else begin
                    n_bad = 1'b1;
                end
                n_digits = r_digits - HDR_W'(1);
                if (r_digits == HDR_W'(1)) begin
                    n_phase = PH_CLOSE;
                end
                if (i_end_of_input) begin
                    emit = 1'b1;
                    res.status = ST_PAST_END;
                end
            end
            PH_CLOSE: begin
                emit = 1'b1;
                if (i_data_byte != BYTE_CLOSE) begin
                    res.status = ST_NO_CLOSE;
                end else if (r_bad) begin
                    res.status = ST_BAD_DIGIT;
                end else begin
                    res.present = 1'b1;
                    res.number  = r_num;
                end
            end
            default: begin
                n_phase = PH_TAG;
            end
        endcase

        // every result restarts the reader
        if (emit) begin
            n_phase      = PH_TAG;
            n_acc        = '0;
            n_first_seen = 1'b0;
            n_digits     = '0;
            n_num        = '0;
            n_bad        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_tag  <= '0;
            r_optional_mode <= 1'b0;
            r_phase         <= PH_TAG;
            r_acc           <= '0;
            r_first_seen    <= 1'b0;
            r_digits        <= '0;
            r_num           <= '0;
            r_bad           <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EXPECTED_TAG:  r_expected_tag  <= i_cfg_data;
                    CFG_OPTIONAL_MODE: r_optional_mode <= i_cfg_data[0];
                    default:           r_optional_mode <= r_optional_mode;
                endcase
            end
            if (in_fire) begin
                r_phase      <= n_phase;
                r_acc        <= n_acc;
                r_first_seen <= n_first_seen;
                r_digits     <= n_digits;
                r_num        <= n_num;
                r_bad        <= n_bad;
            end
        end
    end

    tder_ofifo u_ofifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_fire && emit),
        .i_data      (res),
        .o_can_push  (o_in_ready),
        .o_valid     (o_out_valid),
        .i_pop_ready (i_out_ready),
        .o_data      (q_data)
    );

    assign o_status  = q_data.status;
    assign o_present = q_data.present;
    assign o_number  = q_data.number[31:0];

    a_present_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_present |-> o_status == ST_OK)
        else $error("present result with error status");

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_present |-> o_number == 32'd0)
        else $error("absent or failed result carries a number");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && emit |=> r_phase == PH_TAG && !r_first_seen && !r_bad)
        else $error("reader did not restart after a result");

    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DIGITS |-> r_digits != '0)
        else $error("digit phase with no digits left");

endmodule

`default_nettype wire

@@ tb/sv/tagged_decimal_element_reader_tb.sv @@
`timescale 1ns / 1ps

module tagged_decimal_element_reader_tb;
    import tder_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 350;

    typedef enum logic [1:0] {
        RD_TAG,
        RD_LEN,
        RD_DIGITS,
        RD_CLOSE
    } t_read_phase;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic        i_cfg_index    = CFG_EXPECTED_TAG;
    logic [31:0] i_cfg_data     = '0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte    = '0;
    logic        i_end_of_input = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [2:0]  o_status;
    logic        o_present;
    logic [31:0] o_number;

    // configuration as the block should hold it
    logic [31:0] tag_reg;
    logic        opt_mode;

    // element reader state
    t_read_phase rd_phase;
    logic [31:0] hdr_acc;
    logic        hdr_started;
    logic [31:0] digits_left;
    logic [31:0] digit_acc;
    logic        digit_bad;

    t_result     pending_results[$];
    t_result     want_result;
    int          fail_count;
    int          sent_bytes;
    int          send_idle_pct;
    int          recv_stall_pct;

    tagged_decimal_element_reader u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_present      (o_present),
        .o_number       (o_number)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void post_result(t_status st, logic pres, logic [31:0] num);
        t_result r;
        r.status  = st;
        r.present = pres;
        r.number  = num;
        pending_results.push_back(r);
        rd_phase    = RD_TAG;
        hdr_acc     = '0;
        hdr_started = 1'b0;
        digits_left = '0;
        digit_acc   = '0;
        digit_bad   = 1'b0;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic eoi);
        logic [31:0] hval;
        if (rd_phase == RD_TAG || rd_phase == RD_LEN) begin
            if (!hdr_started && b == BYTE_CLOSE) begin
                // absence only applies where the tag header should start
                if (rd_phase == RD_TAG && opt_mode)
                    post_result(ST_OK, 1'b0, '0);
                else
                    post_result(ST_ZERO_OCTET, 1'b0, '0);
                return;
            end
            hdr_started = 1'b1;
            if (!b[7]) begin
                hdr_acc = {hdr_acc[24:0], b[6:0]};
                if (eoi)
                    post_result(ST_PAST_END, 1'b0, '0);
                return;
            end
            hval        = {hdr_acc[27:0], b[6:3]};
            hdr_acc     = '0;
            hdr_started = 1'b0;
            if (rd_phase == RD_TAG) begin
                if (b[2:0] != TYPE_DTAG) begin
                    post_result(opt_mode ? ST_OK : ST_NOT_DTAG, 1'b0, '0);
                    return;
                end
                if (hval != tag_reg) begin
                    post_result(opt_mode ? ST_OK : ST_WRONG_TAG, 1'b0, '0);
                    return;
                end
                rd_phase = RD_LEN;
            end else begin
                if (b[2:0] != TYPE_UDATA) begin
                    post_result(ST_NOT_UDATA, 1'b0, '0);
                    return;
                end
                digits_left = hval;
                digit_acc   = '0;
                digit_bad   = 1'b0;
                rd_phase    = (hval != 0) ? RD_DIGITS : RD_CLOSE;
            end
            if (eoi)
                post_result(ST_PAST_END, 1'b0, '0);
        end else if (rd_phase == RD_DIGITS) begin
            if (b >= CHR_ZERO && b <= CHR_NINE)
                digit_acc = digit_acc * 32'd10 + 32'(b - CHR_ZERO);
            else
                digit_bad = 1'b1;
            digits_left = digits_left - 1;
            if (digits_left == 0)
                rd_phase = RD_CLOSE;
            if (eoi)
                post_result(ST_PAST_END, 1'b0, '0);
        end else begin
            // missing close outranks a bad digit
            if (b != BYTE_CLOSE)
                post_result(ST_NO_CLOSE, 1'b0, '0);
            else if (digit_bad)
                post_result(ST_BAD_DIGIT, 1'b0, '0);
            else
                post_result(ST_OK, 1'b1, digit_acc);
        end
    endfunction

    function automatic logic rand_eoi();
        return ($urandom_range(99) < 2);
    endfunction

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with none pending: status %0d present %0d number %0d",
                       o_status, o_present, o_number);
                fail_count++;
            end else begin
                want_result = pending_results.pop_front();
                if (o_status !== want_result.status) begin
                    $error("status: expected %0d, got %0d", want_result.status, o_status);
                    fail_count++;
                end
                if (o_present !== want_result.present) begin
                    $error("present: expected %0d, got %0d", want_result.present, o_present);
                    fail_count++;
                end
                if (o_number !== want_result.number) begin
                    $error("number: expected %0d, got %0d", want_result.number, o_number);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic eoi);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (!o_in_ready);
        decode_byte(b, eoi);
        sent_bytes++;
    endtask

    // header as 7-bit groups then a final octet; pad forces a leading group
    // whose bits get shifted out of the 32-bit value
    task automatic send_header(logic [31:0] val, logic [2:0] kind, bit pad, logic eoi);
        logic [27:0] upper;
        int          n;
        upper = val[31:4];
        n     = 0;
        if (pad) begin
            send_byte({1'b0, 7'($urandom_range(127, 1))}, 1'b0);
            n = 4;
        end else begin
            for (int k = 0; k < 4; k++)
                if ((upper >> (7 * k)) != 0)
                    n = k + 1;
        end
        for (int k = n - 1; k >= 0; k--)
            send_byte({1'b0, upper[7*k +: 7]}, 1'b0);
        send_byte({1'b1, val[3:0], kind}, eoi);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_EXPECTED_TAG)
            tag_reg = val;
        else
            opt_mode = val[0];
        @(posedge i_clk);
    endtask

    task automatic test_well_formed_elements();
        settle();
        write_reg(CFG_EXPECTED_TAG, 32'd5);
        write_reg(CFG_OPTIONAL_MODE, 32'd0);
        // zero digits
        send_header(32'd5, TYPE_DTAG, 1'b0, 1'b0);
        send_header(32'd0, TYPE_UDATA, 1'b0, 1'b0);
        send_byte(BYTE_CLOSE, 1'b0);
        // lowest and highest digit
        send_header(32'd5, TYPE_DTAG, 1'b0, 1'b0);
        send_header(32'd2, TYPE_UDATA, 1'b0, 1'b0);
        send_byte(CHR_ZERO, 1'b0);
        send_byte(CHR_NINE, 1'b0);
        send_byte(BYTE_CLOSE, 1'b0);
    endtask

    task automatic test_error_codes();
        send_byte(BYTE_CLOSE, 1'b0);
        send_header(32'd5, TYPE_UDATA, 1'b0, 1'b0);
        send_header(32'd6, TYPE_DTAG, 1'b0, 1'b0);
        send_header(32'd5, TYPE_DTAG, 1'b0, 1'b0);
        send_byte(BYTE_CLOSE, 1'b0);
        send_header(32'd5, TYPE_DTAG, 1'b0, 1'b0);
        send_header(32'd1, TYPE_DTAG, 1'b0, 1'b0);
        send_header(32'd5, TYPE_DTAG, 1'b0, 1'b0);
        send_header(32'd1, TYPE_UDATA, 1'b0, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(BYTE_CLOSE, 1'b0);
        send_header(32'd5, TYPE_DTAG, 1'b0, 1'b0);
        send_header(32'd0, TYPE_UDATA, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_header(32'd5, TYPE_DTAG, 1'b0, 1'b1);
    endtask

    task automatic test_optional_absence();
        settle();
        write_reg(CFG_OPTIONAL_MODE, 32'd1);
        send_byte(BYTE_CLOSE, 1'b0);
        send_header(32'd5, TYPE_UDATA, 1'b0, 1'b0);
        send_header(32'd6, TYPE_DTAG, 1'b0, 1'b0);
    endtask

    task automatic send_random_element();
        logic [31:0] tag;
        logic [2:0]  kind;
        int          len;
        if ($urandom_range(99) < 6) begin
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom), rand_eoi());
            return;
        end
        if ($urandom_range(99) < 3) begin
            send_byte(BYTE_CLOSE, rand_eoi());
            return;
        end
        case ($urandom_range(99)) inside
            [0:84]:  tag = tag_reg;
            [85:91]: tag = tag_reg ^ (32'd1 << $urandom_range(31));
            default: tag = $urandom;
        endcase
        kind = ($urandom_range(99) < 92) ? TYPE_DTAG : 3'($urandom);
        send_header(tag, kind, $urandom_range(99) < 15, rand_eoi());
        if ($urandom_range(99) < 3) begin
            send_byte(BYTE_CLOSE, rand_eoi());
            return;
        end
        len  = ($urandom_range(99) < 85) ? $urandom_range(0, 10) : $urandom_range(11, 24);
        kind = ($urandom_range(99) < 94) ? TYPE_UDATA : 3'($urandom);
        send_header(32'(len), kind, $urandom_range(99) < 10, rand_eoi());
        repeat (len) begin
            if ($urandom_range(99) < 96)
                send_byte(CHR_ZERO + 8'($urandom_range(9)), rand_eoi());
            else
                send_byte(8'($urandom), rand_eoi());
        end
        send_byte(($urandom_range(99) < 94) ? BYTE_CLOSE : 8'($urandom), rand_eoi());
    endtask

    task automatic test_random_stream(int idle_pct, int stall_pct, logic [31:0] tag,
                                      logic opt);
        int goal;
        settle();
        write_reg(CFG_EXPECTED_TAG, tag);
        write_reg(CFG_OPTIONAL_MODE, 32'(opt));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal = sent_bytes + PHASE_BYTES;
        while (sent_bytes < goal)
            send_random_element();
    endtask

    initial begin
        fail_count     = 0;
        sent_bytes     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        tag_reg        = '0;
        opt_mode       = 1'b0;
        post_result(ST_OK, 1'b0, '0);
        pending_results.delete();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_well_formed_elements();
        test_error_codes();
        test_optional_absence();
        test_random_stream(0, 0, $urandom, 1'b0);
        test_random_stream(86, 0, 32'hFFFF_FFFF, 1'b1);
        test_random_stream(0, 86, 32'd0, 1'b0);
        test_random_stream(18, 18, $urandom_range(4095), 1'b1);
        settle();

        if (fail_count == 0)
            $display("tagged_decimal_element_reader_tb: PASS");
        else
            $display("tagged_decimal_element_reader_tb: FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tagged_decimal_element_reader_tb: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tder_pkg.sv
rtl/tder_ofifo.sv
rtl/tagged_decimal_element_reader.sv
tb/sv/tagged_decimal_element_reader_tb.sv
